// ===== rtl/lcas_pkg.sv =====
// Shared constants, codes and types for the load-cell average-and-scale block.
// Used by every module under rtl/; depends on nothing else.
package lcas_pkg;

    // Ring and field sizes
    localparam int MAX_WINDOW  = 64;
    localparam int RING_AW     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int LEN_W       = $clog2(MAX_WINDOW + 1);
    localparam int WIN_FIELD_W = 7;
    localparam int LEN_CMP_W   = (LEN_W > WIN_FIELD_W) ? LEN_W : WIN_FIELD_W;
    localparam int SAMPLE_W    = 25;
    localparam int SUM_W       = SAMPLE_W + RING_AW;
    localparam int FDIV_CNT_W  = $clog2(SUM_W);

    // Calibration datapath sizes
    localparam int OFFSET_W    = 25;
    localparam int GMUL_W      = 31;
    localparam int GDIV_W      = 25;
    localparam int TARE_W      = 32;
    localparam int WEIGHT_W    = 32;
    localparam int PROD_W      = SAMPLE_W + GMUL_W;
    localparam int BDIV_CNT_W  = $clog2(PROD_W);
    localparam int WSUM_W      = PROD_W + 2;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW    = 3'd0,
        CFG_OFFSET    = 3'd1,
        CFG_SCALE_NUM = 3'd2,
        CFG_SCALE_DEN = 3'd3,
        CFG_TARE      = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic                  en;
        t_cfg_idx              idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic [OFFSET_W-1:0]      offset;
        logic [GMUL_W-1:0]        scale_num;
        logic [GDIV_W-1:0]        scale_den;
        logic signed [TARE_W-1:0] tare;
    } t_back_cfg;

    typedef enum logic [2:0] {
        F_IDLE,
        F_SUB,
        F_ADD,
        F_LOAD,
        F_DIV,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_DIV,
        B_RND,
        B_SGN,
        B_TAR,
        B_OUT
    } t_back_state;

endpackage

// ===== rtl/lcas_front.sv =====
// Front end: sample ring, running window sum and serial rounded-average divider.
// Depends on lcas_pkg; pushes each average into lcas_queue.
module lcas_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [lcas_pkg::SAMPLE_W-1:0] i_sample,
    input  lcas_pkg::t_cfg_wr        i_cfg,
    output logic                     o_push,
    output logic [lcas_pkg::SAMPLE_W-1:0] o_push_avg,
    input  logic                     i_q_full
);
    import lcas_pkg::*;

    t_front_state r_state, n_state;

    logic [SAMPLE_W-1:0]   ring [MAX_WINDOW];
    logic [SAMPLE_W-1:0]   r_rd;
    logic [SAMPLE_W-1:0]   r_sample;
    logic [SUM_W-1:0]      r_sum;
    logic [RING_AW-1:0]    r_idx;
    logic [LEN_W-1:0]      r_len;
    logic [LEN_W-1:0]      r_fill;
    logic [SAMPLE_W-1:0]   r_refill;
    logic [SAMPLE_W-1:0]   r_last_avg;
    logic [SUM_W-1:0]      r_num;
    logic [LEN_W-1:0]      r_rem;
    logic [FDIV_CNT_W-1:0] r_cnt;

    logic                      ring_we;
    logic [SAMPLE_W-1:0]       old_sample;
    logic [LEN_W-1:0]          idx_inc;
    logic [LEN_W:0]            rem_sh;
    logic                      q_bit;
    logic [WIN_FIELD_W-1:0]    wr_len;
    logic [LEN_CMP_W-1:0]      wr_len_x;
    logic [LEN_W-1:0]          wr_len_clamp;
    logic                      win_write;
    logic [SAMPLE_W+LEN_W-1:0] fill_prod;

    // Entries at or past the fill count still hold the refill value
    assign old_sample = (LEN_W'(r_idx) >= r_fill) ? r_refill : r_rd;
    assign idx_inc    = LEN_W'(r_idx) + LEN_W'(1);

    // One restoring divide step by the window length
    assign rem_sh = {r_rem, r_num[SUM_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, r_len});

    // Window length write: clamp and decide whether to refill
    assign wr_len   = i_cfg.data[WIN_FIELD_W-1:0];
    assign wr_len_x = LEN_CMP_W'(wr_len);
    always_comb begin
        if (wr_len_x == '0) begin
            wr_len_clamp = LEN_W'(1);
        end else if (wr_len_x > LEN_CMP_W'(MAX_WINDOW)) begin
            wr_len_clamp = LEN_W'(MAX_WINDOW);
        end else begin
            wr_len_clamp = wr_len_x[LEN_W-1:0];
        end
    end
    assign win_write = i_cfg.en && (i_cfg.idx == CFG_WINDOW)
                       && (wr_len_x != LEN_CMP_W'(r_len));
    assign fill_prod = r_last_avg * wr_len_clamp;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: if (i_valid) n_state = F_SUB;
            F_SUB:  n_state = F_ADD;
            F_ADD:  n_state = F_LOAD;
            F_LOAD: n_state = F_DIV;
            F_DIV:  if (r_cnt == FDIV_CNT_W'(SUM_W - 1)) n_state = F_PUSH;
            F_PUSH: if (!i_q_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_stall = 1'b1;
        o_push  = 1'b0;
        ring_we = 1'b0;
        case (r_state)
            F_IDLE: o_stall = 1'b0;
            F_SUB:  ring_we = 1'b1;
            F_PUSH: o_push  = !i_q_full;
            default: ;
        endcase
    end

    assign o_push_avg = r_num[SAMPLE_W-1:0];

    // Sample ring, read registered at the current index
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            ring[r_idx] <= r_sample;
        end
        r_rd <= ring[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Window state and refill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum      <= '0;
            r_idx      <= '0;
            r_len      <= LEN_W'(4);
            r_fill     <= '0;
            r_refill   <= '0;
            r_last_avg <= '0;
        end else if (win_write) begin
            r_len    <= wr_len_clamp;
            r_refill <= r_last_avg;
            r_fill   <= '0;
            r_idx    <= '0;
            r_sum    <= fill_prod[SUM_W-1:0];
        end else begin
            case (r_state)
                F_SUB: begin
                    r_sum <= r_sum - SUM_W'(old_sample);
                    if (LEN_W'(r_idx) == r_fill) begin
                        r_fill <= r_fill + LEN_W'(1);
                    end
                    if (idx_inc >= r_len) begin
                        r_idx <= '0;
                    end else begin
                        r_idx <= idx_inc[RING_AW-1:0];
                    end
                end
                F_ADD:  r_sum <= r_sum + SUM_W'(r_sample);
                F_PUSH: if (!i_q_full) r_last_avg <= r_num[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    // Sample capture and average divider
    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: if (i_valid) r_sample <= i_sample;
            F_LOAD: begin
                r_num <= r_sum + SUM_W'(r_len >> 1);
                r_rem <= '0;
                r_cnt <= '0;
            end
            F_DIV: begin
                r_num <= {r_num[SUM_W-2:0], q_bit};
                if (q_bit) begin
                    r_rem <= LEN_W'(rem_sh - {1'b0, r_len});
                end else begin
                    r_rem <= rem_sh[LEN_W-1:0];
                end
                r_cnt <= r_cnt + FDIV_CNT_W'(1);
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/lcas_queue.sv =====
// Short FIFO of averages between the front and back ends.
// Depends on lcas_pkg for depth and data width.
module lcas_queue (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  logic [lcas_pkg::SAMPLE_W-1:0] i_data,
    output logic                     o_full,
    input  logic                     i_pop,
    output logic [lcas_pkg::SAMPLE_W-1:0] o_data,
    output logic                     o_empty
);
    import lcas_pkg::*;

    logic [SAMPLE_W-1:0] r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Store entry
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                            : r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                            : r_rd_ptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/lcas_back.sv =====
// Back end: offset, gain multiply, serial rounded divide, tare and saturation.
// Depends on lcas_pkg; pops averages from lcas_queue and drives the result register.
module lcas_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lcas_pkg::t_back_cfg           i_cfg,
    input  logic                          i_q_empty,
    input  logic [lcas_pkg::SAMPLE_W-1:0] i_q_data,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [lcas_pkg::WEIGHT_W-1:0] o_weight,
    output logic [lcas_pkg::SAMPLE_W-1:0] o_average
);
    import lcas_pkg::*;

    t_back_state r_state, n_state;

    logic [SAMPLE_W-1:0]       r_avg;
    logic                      r_neg;
    logic [SAMPLE_W-1:0]       r_mag;
    logic [PROD_W-1:0]         r_num;
    logic [GDIV_W-1:0]         r_rem;
    logic [BDIV_CNT_W-1:0]     r_cnt;
    logic [PROD_W-1:0]         r_q;
    logic signed [WSUM_W-1:0]  r_s;
    logic signed [WSUM_W-1:0]  r_w;
    logic                      r_out_valid;
    logic signed [WEIGHT_W-1:0] r_out_weight;
    logic [SAMPLE_W-1:0]       r_out_avg;

    logic                      load_out;
    logic                      q_neg;
    logic [PROD_W-1:0]         prod;
    logic [GDIV_W:0]           rem_sh;
    logic                      q_bit;
    logic                      round_up;
    logic                      w_ovf;
    logic signed [WEIGHT_W-1:0] w_sat;

    assign q_neg = (i_q_data < i_cfg.offset);
    assign prod  = r_mag * i_cfg.scale_num;

    // One restoring divide step by the gain divisor
    assign rem_sh   = {r_rem, r_num[PROD_W-1]};
    assign q_bit    = (rem_sh >= {1'b0, i_cfg.scale_den});
    assign round_up = (r_rem > (i_cfg.scale_den >> 1));

    // Saturate when the upper bits are not a pure sign extension
    assign w_ovf = (r_w[WSUM_W-1:WEIGHT_W-1] != '0) && (r_w[WSUM_W-1:WEIGHT_W-1] != '1);
    always_comb begin
        if (!w_ovf) begin
            w_sat = r_w[WEIGHT_W-1:0];
        end else if (r_w[WSUM_W-1]) begin
            w_sat = {1'b1, {(WEIGHT_W-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(WEIGHT_W-1){1'b1}}};
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: if (!i_q_empty) n_state = B_MUL;
            B_MUL:  n_state = B_DIV;
            B_DIV:  if (r_cnt == BDIV_CNT_W'(PROD_W - 1)) n_state = B_RND;
            B_RND:  n_state = B_SGN;
            B_SGN:  n_state = B_TAR;
            B_TAR:  n_state = B_OUT;
            B_OUT:  if (!r_out_valid || !i_stall) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_pop    = 1'b0;
        load_out = 1'b0;
        case (r_state)
            B_IDLE: o_pop    = !i_q_empty;
            B_OUT:  load_out = !r_out_valid || !i_stall;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Calibration datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    r_avg <= i_q_data;
                    r_neg <= q_neg;
                    r_mag <= q_neg ? i_cfg.offset - i_q_data : i_q_data - i_cfg.offset;
                end
            end
            B_MUL: begin
                r_num <= prod;
                r_rem <= '0;
                r_cnt <= '0;
            end
            B_DIV: begin
                r_num <= {r_num[PROD_W-2:0], q_bit};
                if (q_bit) begin
                    r_rem <= GDIV_W'(rem_sh - {1'b0, i_cfg.scale_den});
                end else begin
                    r_rem <= rem_sh[GDIV_W-1:0];
                end
                r_cnt <= r_cnt + BDIV_CNT_W'(1);
            end
            B_RND:  r_q <= r_num + PROD_W'(round_up);
            B_SGN:  r_s <= r_neg ? -$signed({2'b00, r_q}) : $signed({2'b00, r_q});
            B_TAR:  r_w <= r_s + WSUM_W'(i_cfg.tare);
            default: ;
        endcase
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_weight <= w_sat;
            r_out_avg    <= r_avg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_weight  = r_out_weight;
    assign o_average = r_out_avg;

endmodule

// ===== rtl/load_cell_average_and_scale.sv =====
// Load-cell moving average with offset, gain and tare calibration.
// The front end runs a 31-step average divider and pushes each average into the queue; the back
// end pops it, runs a 56-step gain divider and loads the result register behind o_result_valid.
// Throughput is set by the back end; the front end, buffered by the queue, is the faster of the two.
// Synchronous active-low reset clears the window, average and registers to defaults.
// Depends on lcas_pkg, lcas_front, lcas_queue and lcas_back.
module load_cell_average_and_scale (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_sample_valid,
    output logic                            o_sample_stall,
    input  logic [lcas_pkg::SAMPLE_W-1:0]   i_sample,
    output logic                            o_result_valid,
    input  logic                            i_result_stall,
    output logic signed [lcas_pkg::WEIGHT_W-1:0] o_weight,
    output logic [lcas_pkg::SAMPLE_W-1:0]   o_average,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lcas_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lcas_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lcas_pkg::*;

    t_cfg_wr             cfg_wr;
    t_back_cfg           r_cfg;
    logic                q_push;
    logic [SAMPLE_W-1:0] q_push_data;
    logic                q_full;
    logic                q_pop;
    logic [SAMPLE_W-1:0] q_data;
    logic                q_empty;

    // Configuration writes are always accepted
    assign o_cfg_ready  = 1'b1;
    assign cfg_wr.en    = i_cfg_valid && o_cfg_ready;
    assign cfg_wr.idx   = t_cfg_idx'(i_cfg_index);
    assign cfg_wr.data  = i_cfg_data;

    // Calibration registers; zero divisor is stored as one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.offset    <= '0;
            r_cfg.scale_num <= GMUL_W'(1);
            r_cfg.scale_den <= GDIV_W'(1);
            r_cfg.tare      <= '0;
        end else if (cfg_wr.en) begin
            case (cfg_wr.idx)
                CFG_WINDOW:    ;
                CFG_OFFSET:    r_cfg.offset    <= i_cfg_data[OFFSET_W-1:0];
                CFG_SCALE_NUM: r_cfg.scale_num <= i_cfg_data[GMUL_W-1:0];
                CFG_SCALE_DEN: begin
                    if (i_cfg_data[GDIV_W-1:0] == '0) begin
                        r_cfg.scale_den <= GDIV_W'(1);
                    end else begin
                        r_cfg.scale_den <= i_cfg_data[GDIV_W-1:0];
                    end
                end
                CFG_TARE:      r_cfg.tare      <= $signed(i_cfg_data[TARE_W-1:0]);
                default: ;
            endcase
        end
    end

    lcas_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_sample_valid),
        .o_stall    (o_sample_stall),
        .i_sample   (i_sample),
        .i_cfg      (cfg_wr),
        .o_push     (q_push),
        .o_push_avg (q_push_data),
        .i_q_full   (q_full)
    );

    lcas_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_push_data),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_empty (q_empty)
    );

    lcas_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_q_data  (q_data),
        .o_pop     (q_pop),
        .o_valid   (o_result_valid),
        .i_stall   (i_result_stall),
        .o_weight  (o_weight),
        .o_average (o_average)
    );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for load_cell_average_and_scale: directed table, then random
// calibration settings and sample streams, scored against an in-bench weight predictor.
// Depends on lcas_pkg and the RTL under rtl/.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lcas_pkg::*;

    localparam int          CLK_PERIOD    = 12;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int          DRAIN_CYCLES  = 150;
    localparam int          PHASE_ITEMS   = 417;
    localparam logic [SAMPLE_W-1:0] SAMPLE_HIGH = 25'd25165824;
    localparam logic [SAMPLE_W-1:0] SAMPLE_ONES = '1;
    localparam logic [31:0] W_TOP         = 32'h7fff_ffff;
    localparam logic [31:0] W_BOTTOM      = 32'h8000_0000;
    localparam longint      W_MAX         = 64'sd2147483647;
    localparam longint      W_MIN         = -64'sd2147483648;
    // Register indexes that decode to nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic signed [WEIGHT_W-1:0] weight;
        logic [SAMPLE_W-1:0]        average;
    } t_weigh_result;

    typedef enum logic {ROW_WRITE, ROW_SAMPLE} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        bit                    typed;
        t_weigh_result         res;
    } t_plan_row;

    // DUT connections
    logic                            i_clk          = 1'b0;
    logic                            i_rst_n        = 1'b0;
    logic                            i_sample_valid = 1'b0;
    logic                            o_sample_stall;
    logic [SAMPLE_W-1:0]             i_sample       = '0;
    logic                            o_result_valid;
    logic                            i_result_stall = 1'b0;
    logic signed [WEIGHT_W-1:0]      o_weight;
    logic [SAMPLE_W-1:0]             o_average;
    logic                            i_cfg_valid    = 1'b0;
    logic                            o_cfg_ready;
    logic [CFG_IDX_W-1:0]            i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0]           i_cfg_data     = '0;

    // Predictor state: sample window and calibration registers
    logic [SAMPLE_W-1:0]        win_ring [MAX_WINDOW] = '{default: '0};
    logic [63:0]                win_sum    = '0;
    int unsigned                win_pos    = 0;
    logic [SAMPLE_W-1:0]        avg_last   = '0;
    int unsigned                cal_len    = 4;
    logic [OFFSET_W-1:0]        cal_offset = '0;
    logic [GMUL_W-1:0]          cal_gmul   = 31'd1;
    logic [GDIV_W-1:0]          cal_gdiv   = 25'd1;
    logic signed [TARE_W-1:0]   cal_tare   = '0;

    t_weigh_result pending_readings [$];
    t_weigh_result oldest_reading;
    int unsigned   send_idle_pct = 10;
    int unsigned   recv_idle_pct = 84;
    int unsigned   cycle_count   = 0;
    int            fault_count   = 0;

    // Directed stimulus; typed expectations only where they are obvious
    t_plan_row plan [$] = '{
        '{ROW_SAMPLE, CFG_WINDOW,   32'd0,           1'b1, '{32'sd0, 25'd0}},
        '{ROW_SAMPLE, CFG_WINDOW,   32'(SAMPLE_HIGH), 1'b1, '{32'sd6291456, 25'd6291456}},
        '{ROW_SAMPLE, CFG_WINDOW,   32'(SAMPLE_ONES), 1'b0, '{32'sd0, 25'd0}},
        '{ROW_WRITE,  CFG_WINDOW,   32'd1,           1'b0, '{32'sd0, 25'd0}},
        '{ROW_WRITE,  CFG_OFFSET,   32'(SAMPLE_HIGH), 1'b0, '{32'sd0, 25'd0}},
        '{ROW_WRITE,  CFG_SCALE_NUM, W_TOP,          1'b0, '{32'sd0, 25'd0}},
        '{ROW_WRITE,  CFG_TARE,     W_BOTTOM,        1'b0, '{32'sd0, 25'd0}},
        '{ROW_SAMPLE, CFG_WINDOW,   32'd0,           1'b1, '{W_BOTTOM, 25'd0}},
        '{ROW_SAMPLE, CFG_WINDOW,   32'(SAMPLE_HIGH), 1'b1, '{W_BOTTOM, SAMPLE_HIGH}},
        '{ROW_WRITE,  CFG_TARE,     W_TOP,           1'b0, '{32'sd0, 25'd0}},
        '{ROW_WRITE,  CFG_OFFSET,   32'd0,           1'b0, '{32'sd0, 25'd0}},
        '{ROW_SAMPLE, CFG_WINDOW,   32'(SAMPLE_HIGH), 1'b1, '{W_TOP, SAMPLE_HIGH}},
        '{ROW_SAMPLE, CFG_WINDOW,   32'(SAMPLE_ONES), 1'b1, '{W_TOP, SAMPLE_ONES}},
        '{ROW_WRITE,  CFG_WINDOW,   32'd0,           1'b0, '{32'sd0, 25'd0}},
        '{ROW_WRITE,  CFG_WINDOW,   32'd127,         1'b0, '{32'sd0, 25'd0}},
        '{ROW_SAMPLE, CFG_WINDOW,   32'd0,           1'b0, '{32'sd0, 25'd0}},
        '{ROW_WRITE,  CFG_WINDOW,   32'd64,          1'b0, '{32'sd0, 25'd0}},
        '{ROW_SAMPLE, CFG_WINDOW,   32'd0,           1'b0, '{32'sd0, 25'd0}},
        '{ROW_WRITE,  CFG_WINDOW,   32'd1,           1'b0, '{32'sd0, 25'd0}},
        '{ROW_WRITE,  CFG_TARE,     32'd0,           1'b0, '{32'sd0, 25'd0}},
        '{ROW_WRITE,  CFG_OFFSET,   32'd10,          1'b0, '{32'sd0, 25'd0}},
        '{ROW_WRITE,  CFG_SCALE_NUM, 32'd1,          1'b0, '{32'sd0, 25'd0}},
        '{ROW_WRITE,  CFG_SCALE_DEN, 32'd3,          1'b0, '{32'sd0, 25'd0}},
        '{ROW_WRITE,  CFG_SCALE_DEN, 32'd0,          1'b0, '{32'sd0, 25'd0}},
        '{ROW_SAMPLE, CFG_WINDOW,   32'd12,          1'b1, '{32'sd2, 25'd12}},
        '{ROW_WRITE,  CFG_SCALE_DEN, 32'd2,          1'b0, '{32'sd0, 25'd0}},
        '{ROW_SAMPLE, CFG_WINDOW,   32'd11,          1'b1, '{32'sd0, 25'd11}},
        '{ROW_SAMPLE, CFG_WINDOW,   32'd13,          1'b1, '{32'sd1, 25'd13}},
        '{ROW_SAMPLE, CFG_WINDOW,   32'd7,           1'b1, '{32'hffff_ffff, 25'd7}},
        '{ROW_WRITE,  CFG_SCALE_DEN, 32'd3,          1'b0, '{32'sd0, 25'd0}},
        '{ROW_SAMPLE, CFG_WINDOW,   32'd12,          1'b1, '{32'sd1, 25'd12}},
        '{ROW_SAMPLE, CFG_WINDOW,   32'd8,           1'b1, '{32'hffff_ffff, 25'd8}},
        '{ROW_SAMPLE, CFG_WINDOW,   32'd10,          1'b1, '{32'sd0, 25'd10}},
        '{ROW_WRITE,  CFG_UNUSED_LO, 32'hffff_ffff,  1'b0, '{32'sd0, 25'd0}},
        '{ROW_WRITE,  CFG_UNUSED_HI, 32'd0,          1'b0, '{32'sd0, 25'd0}},
        '{ROW_SAMPLE, CFG_WINDOW,   32'd13,          1'b1, '{32'sd1, 25'd13}},
        '{ROW_WRITE,  CFG_SCALE_DEN, 32'(SAMPLE_HIGH), 1'b0, '{32'sd0, 25'd0}},
        '{ROW_WRITE,  CFG_SCALE_NUM, W_TOP,          1'b0, '{32'sd0, 25'd0}},
        '{ROW_WRITE,  CFG_TARE,     32'hffff_fffb,   1'b0, '{32'sd0, 25'd0}},
        '{ROW_SAMPLE, CFG_WINDOW,   32'(SAMPLE_HIGH), 1'b0, '{32'sd0, 25'd0}},
        '{ROW_SAMPLE, CFG_WINDOW,   32'd3,           1'b0, '{32'sd0, 25'd0}}
    };

    load_cell_average_and_scale u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .o_sample_stall (o_sample_stall),
        .i_sample       (i_sample),
        .o_result_valid (o_result_valid),
        .i_result_stall (i_result_stall),
        .o_weight       (o_weight),
        .o_average      (o_average),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Update the window with one sample and compute the calibrated weight
    function automatic t_weigh_result weigh_sample(input logic [SAMPLE_W-1:0] s);
        t_weigh_result res;
        int unsigned   n;
        int unsigned   p;
        logic          neg;
        logic [63:0]   mag;
        logic [63:0]   prod;
        logic [63:0]   quo;
        logic [63:0]   rem;
        longint        wl;
        n = cal_len;
        p = win_pos;
        if (n < 1 || n > MAX_WINDOW) n = 1;
        if (p >= n) p = 0;
        win_sum     = win_sum - 64'(win_ring[p]) + 64'(s);
        win_ring[p] = s;
        win_pos     = (p + 1) % n;
        avg_last    = SAMPLE_W'((win_sum + 64'(n / 2)) / 64'(n));
        // Offset, then scale the magnitude with round-half-down on the remainder
        neg  = avg_last < cal_offset;
        mag  = neg ? 64'(cal_offset - avg_last) : 64'(avg_last - cal_offset);
        prod = mag * 64'(cal_gmul);
        quo  = prod / 64'(cal_gdiv);
        rem  = prod % 64'(cal_gdiv);
        if (rem > 64'(cal_gdiv / 2)) quo = quo + 64'd1;
        // Restore sign, add tare, saturate
        wl = neg ? -longint'(quo) : longint'(quo);
        wl = wl + longint'(cal_tare);
        if (wl > W_MAX) wl = W_MAX;
        else if (wl < W_MIN) wl = W_MIN;
        res.weight  = WEIGHT_W'(wl);
        res.average = avg_last;
        return res;
    endfunction

    // Mirror a register write into the predictor
    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] d);
        int unsigned n;
        n = 32'(d[6:0]);
        case (idx)
            CFG_WINDOW: begin
                if (n != cal_len) begin
                    if (n < 1) n = 1;
                    else if (n > MAX_WINDOW) n = MAX_WINDOW;
                    cal_len = n;
                    for (int k = 0; k < cal_len; k++) win_ring[k] = avg_last;
                    win_pos = 0;
                    win_sum = 64'(avg_last) * 64'(cal_len);
                end
            end
            CFG_OFFSET:    cal_offset = d[OFFSET_W-1:0];
            CFG_SCALE_NUM: cal_gmul   = d[GMUL_W-1:0];
            CFG_SCALE_DEN: cal_gdiv   = (d[GDIV_W-1:0] == '0) ? 25'd1 : d[GDIV_W-1:0];
            CFG_TARE:      cal_tare   = d;
            default: ;
        endcase
    endfunction

    // Register write: hold samples off, wait for all readings, then one transaction
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        i_sample_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, d);
    endtask

    // Sample transaction with random idle gaps; record the expected reading
    task automatic send_sample(input logic [SAMPLE_W-1:0] s, input bit typed,
                               input t_weigh_result typed_res);
        t_weigh_result predicted;
        i_cfg_valid <= 1'b0;
        while ($urandom_range(99, 0) < send_idle_pct) begin
            i_sample_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_sample_valid <= 1'b1;
        i_sample       <= s;
        do @(posedge i_clk); while (o_sample_stall);
        predicted = weigh_sample(s);
        pending_readings.push_back(typed ? typed_res : predicted);
    endtask

    // Result side: random stall, compare each accepted reading with the oldest one
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid && !i_result_stall) begin
            if (pending_readings.size() == 0) begin
                $display("%0t: unexpected reading, expected none, got weight %0d average %0d",
                         $time, o_weight, o_average);
                fault_count++;
            end else begin
                oldest_reading = pending_readings.pop_front();
                if (o_weight !== oldest_reading.weight) begin
                    $display("%0t: weight mismatch, expected %0d, got %0d",
                             $time, oldest_reading.weight, o_weight);
                    fault_count++;
                end
                if (o_average !== oldest_reading.average) begin
                    $display("%0t: average mismatch, expected %0d, got %0d",
                             $time, oldest_reading.average, o_average);
                    fault_count++;
                end
            end
        end
        i_result_stall <= ($urandom_range(99, 0) < recv_idle_pct);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int                    made;
        int                    blk_len;
        int                    center;
        int                    spread;
        int                    value;
        int unsigned           pick;
        logic [CFG_DATA_W-1:0] data;
        logic [CFG_DATA_W-1:0] gdata;
        logic [SAMPLE_W-1:0]   smp;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        foreach (plan[r]) begin
            if (plan[r].kind == ROW_WRITE) write_reg(plan[r].idx, plan[r].data);
            else send_sample(plan[r].data[SAMPLE_W-1:0], plan[r].typed, plan[r].res);
        end

        // Random part: receiver-heavy idling, then sender-heavy, then none
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 84 : 0;
            recv_idle_pct = (phase == 0) ? 84 : (phase == 1) ? 10 : 0;
            made = 0;
            while (made < PHASE_ITEMS) begin
                // Pick a load level and a calibration around it
                center = ($urandom_range(7, 0) == 0) ? int'($urandom_range(33554431, 0))
                                                    : int'($urandom_range(25165824, 0));
                spread = ($urandom_range(7, 0) == 0) ? 0 : int'($urandom_range(4000, 0));

                pick = $urandom_range(15, 0);
                data = $urandom();
                data[6:0] = (pick == 0) ? 7'd1 : (pick == 1) ? 7'd64 : (pick == 2) ? 7'd0 :
                            (pick == 3) ? 7'($urandom_range(127, 65))
                                        : 7'($urandom_range(64, 1));
                write_reg(CFG_WINDOW, data);

                value = center + int'($urandom_range(2000, 0)) - 1000;
                if (value < 0) value = 0;
                if (value > int'(SAMPLE_HIGH)) value = int'(SAMPLE_HIGH);
                data = $urandom();
                data[OFFSET_W-1:0] = ($urandom_range(15, 0) == 0) ? 25'($urandom())
                                                                  : value[OFFSET_W-1:0];
                write_reg(CFG_OFFSET, data);

                pick  = $urandom_range(3, 0);
                data  = $urandom();
                gdata = $urandom();
                if (pick < 2) begin
                    data[GMUL_W-1:0]  = 31'($urandom_range(1000, 1));
                    gdata[GDIV_W-1:0] = 25'($urandom_range(1000, 1));
                end else if (pick == 2) begin
                    gdata[GDIV_W-1:0] = 25'($urandom_range(25165824, 1 << 20));
                end else if ($urandom_range(7, 0) == 0) begin
                    gdata[GDIV_W-1:0] = '0;
                end
                write_reg(CFG_SCALE_NUM, data);
                write_reg(CFG_SCALE_DEN, gdata);

                data = ($urandom_range(3, 0) == 0) ? $urandom()
                                                   : 32'(int'($urandom_range(2000000, 0))
                                                         - 1000000);
                write_reg(CFG_TARE, data);

                if ($urandom_range(3, 0) == 0)
                    write_reg(3'($urandom_range(CFG_UNUSED_HI, CFG_UNUSED_LO)), $urandom());

                // Stream of samples: mostly noise around the level, some wild values
                blk_len = $urandom_range(80, 20);
                if (blk_len > PHASE_ITEMS - made) blk_len = PHASE_ITEMS - made;
                for (int k = 0; k < blk_len; k++) begin
                    pick = $urandom_range(99, 0);
                    if (pick < 80) begin
                        value = center + int'($urandom_range(2 * spread, 0)) - spread;
                        if (value < 0) value = 0;
                        if (value > int'(SAMPLE_ONES)) value = int'(SAMPLE_ONES);
                        smp = value[SAMPLE_W-1:0];
                    end else if (pick < 95) begin
                        smp = 25'($urandom());
                    end else begin
                        case ($urandom_range(2, 0))
                            0:       smp = '0;
                            1:       smp = SAMPLE_HIGH;
                            default: smp = SAMPLE_ONES;
                        endcase
                    end
                    send_sample(smp, 1'b0, '0);
                end
                made += blk_len;
            end
        end

        // Drain and look for stray readings
        i_sample_valid <= 1'b0;
        i_cfg_valid    <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fault_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
